>>> rtl/core/sprite_outline_rim_core_defines.svh
// Assertion helpers for the checker file of the outline core.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef SPRITE_OUTLINE_RIM_CORE_DEFINES_SVH
`define SPRITE_OUTLINE_RIM_CORE_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define SOR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent.
`define SOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sor_pkg.sv
`default_nettype none

package sor_pkg;

  localparam int PIX_W      = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int WREG_W     = 6;
  localparam int HREG_W     = 13;
  localparam int ROW_W      = 12;

  localparam logic [WREG_W-1:0] WIDTH_RST  = 6'd32;
  localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd32;
  localparam logic [PIX_W-1:0]  RIM_RST    = 32'hFF00_0000;
  localparam logic [HREG_W-1:0] MAX_HEIGHT = 13'd4096;

  // Command queue depth and result queue depth.
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 3;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RIM    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_FLUSH = 1'b1
  } back_state_t;

  // Classification of one accepted pixel, handed from front to back.
  typedef struct packed {
    logic solid;      // pixel counts as shape
    logic emit;       // row above this one is awaiting output
    logic up_ok;      // the awaiting row has a row above it
    logic row_end;
    logic frame_end;
  } cmd_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/sprite_outline_rim_core.sv
// Draws a one-pixel rim around the shape of an RGBA frame streamed in raster
// order. A pixel is shape when its alpha is nonzero and it differs from the
// rim colour; a non-shape pixel with a shape pixel left, right, above or below
// it inside the frame is replaced by the rim colour, all others pass through.
// Output pixel (x,y) leaves once input (x,y+1) has been taken, and the last
// input of a frame releases the whole final row, whose last pixel carries
// out_frame_end. The block takes one pixel per clock cycle while its command
// queue has room and delivers one result per cycle while the consumer is
// ready. At the end of a frame the back end sends the final row one pixel at
// a time, one read of the row store per cycle while the result queue has
// room, while the front keeps taking pixels of the next frame into its
// four-entry command queue. Registers: image_width at 0x0, image_height at
// 0x4, rim_colour at 0x8 (alpha, blue, green, red bytes, red lowest); write
// them only while the block is idle.
`default_nettype none

module sprite_outline_rim_core #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_red,
  input  wire logic [7:0]                     in_green,
  input  wire logic [7:0]                     in_blue,
  input  wire logic [7:0]                     in_alpha,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic [7:0]                          out_alpha,
  output logic                                out_frame_end,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sor_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  import sor_pkg::*;

  localparam int IDX_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int W_W     = IDX_W + 1;
  localparam int FLAGS_W = $bits(cmd_flags_t);
  localparam int CMD_W   = FLAGS_W + IDX_W + PIX_W;
  localparam int RES_W   = PIX_W + 1;

  logic [WREG_W-1:0] image_width_r;
  logic [HREG_W-1:0] image_height_r;
  logic [PIX_W-1:0]  rim_colour_r;
  logic              cfg_wr;
  logic [1:0]        reg_sel;

  logic [W_W-1:0]    eff_w;
  logic [HREG_W-1:0] eff_h;

  logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_flags_t        push_flags, pop_flags;
  logic [IDX_W-1:0]  push_col, pop_col;
  logic [PIX_W-1:0]  push_pix, pop_pix;
  logic [CMD_W-1:0]  cmd_wr_word, cmd_rd_word;

  logic              res_valid, res_last;
  logic [PIX_W-1:0]  res_pix;
  logic              out_full, out_empty;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic [RES_W-1:0]  out_word;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
      rim_colour_r   <= RIM_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  image_width_r  <= pwdata[WREG_W-1:0];
        REG_HEIGHT: image_height_r <= pwdata[HREG_W-1:0];
        REG_RIM:    rim_colour_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = {{(32 - WREG_W){1'b0}}, image_width_r};
      REG_HEIGHT: prdata = {{(32 - HREG_W){1'b0}}, image_height_r};
      REG_RIM:    prdata = rim_colour_r;
      default:    prdata = '0;
    endcase
  end

  // Out-of-range sizes are clamped to the supported range.
  always_comb begin
    if (image_width_r == '0) begin
      eff_w = W_W'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(image_width_r);
    end
    if (image_height_r == '0) begin
      eff_h = HREG_W'(1);
    end else if (image_height_r > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end else begin
      eff_h = image_height_r;
    end
  end

  sor_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    ({in_alpha, in_blue, in_green, in_red}),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .rim       (rim_colour_r),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_flags (push_flags),
    .cmd_col   (push_col),
    .cmd_pix   (push_pix)
  );

  assign cmd_wr_word = {push_flags, push_col, push_pix};
  assign {pop_flags, pop_col, pop_pix} = cmd_rd_word;

  sor_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wr_word),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_rd_word),
    .empty     (cmd_empty),
    .count     ()
  );

  sor_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_ready (cmd_pop),
    .cmd_flags (pop_flags),
    .cmd_col   (pop_col),
    .cmd_pix   (pop_pix),
    .eff_w     (eff_w),
    .rim       (rim_colour_r),
    .out_cnt   (out_cnt),
    .res_valid (res_valid),
    .res_pix   (res_pix),
    .res_last  (res_last)
  );

  sor_fifo #(
    .DATA_W (RES_W),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data ({res_pix, res_last}),
    .full      (out_full),
    .pop       (out_valid && out_ready),
    .pop_data  (out_word),
    .empty     (out_empty),
    .count     (out_cnt)
  );

  // The back end never issues into a full result queue, so full only gates
  // the push inside the queue.
  assign out_valid = !out_empty && !(out_full && 1'b0);
  assign {out_alpha, out_blue, out_green, out_red, out_frame_end} = out_word;

endmodule

`default_nettype wire

>>> rtl/core/sor_fifo.sv
`default_nettype none

module sor_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [DATA_W-1:0]          push_data,
  output logic                            full,
  input  wire logic                       pop,
  output logic [DATA_W-1:0]               pop_data,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign pop_data = store_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sor_front.sv
`default_nettype none

module sor_front #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic [sor_pkg::PIX_W-1:0]                    in_pix,
  input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1):0] eff_w,
  input  wire logic [sor_pkg::HREG_W-1:0]                   eff_h,
  input  wire logic [sor_pkg::PIX_W-1:0]                    rim,
  input  wire logic                                         cmd_full,
  output logic                                              cmd_push,
  output sor_pkg::cmd_flags_t                               cmd_flags,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_col,
  output logic [sor_pkg::PIX_W-1:0]                         cmd_pix
);

  import sor_pkg::*;

  localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int W_W   = IDX_W + 1;

  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [W_W-1:0]    col_p1;
  logic [HREG_W-1:0] row_p1;
  logic              accept;
  logic              row_end;
  logic              frame_end;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept;
  assign cmd_pix  = in_pix;

  assign col_p1    = {1'b0, col_r} + W_W'(1);
  assign row_p1    = {1'b0, row_r} + HREG_W'(1);
  assign row_end   = (col_p1 >= eff_w);
  assign frame_end = row_end && (row_p1 >= eff_h);

  // A column left over from a wider setting lands on the last column.
  assign cmd_col = ({1'b0, col_r} >= eff_w) ? IDX_W'(eff_w - W_W'(1)) : col_r;

  always_comb begin
    cmd_flags.solid     = (in_pix[31:24] != 8'd0) && (in_pix != rim);
    cmd_flags.emit      = (row_r != '0);
    cmd_flags.up_ok     = (row_r > ROW_W'(1));
    cmd_flags.row_end   = row_end;
    cmd_flags.frame_end = frame_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_p1[ROW_W-1:0];
      end else begin
        col_nxt = col_p1[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sor_back.sv
`default_nettype none

module sor_back #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         cmd_valid,
  output logic                                              cmd_ready,
  input  wire sor_pkg::cmd_flags_t                          cmd_flags,
  input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_col,
  input  wire logic [sor_pkg::PIX_W-1:0]                    cmd_pix,
  input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1):0] eff_w,
  input  wire logic [sor_pkg::PIX_W-1:0]                    rim,
  input  wire logic [sor_pkg::OUT_CNT_W-1:0]                out_cnt,
  output logic                                              res_valid,
  output logic [sor_pkg::PIX_W-1:0]                         res_pix,
  output logic                                              res_last
);

  import sor_pkg::*;

  localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int W_W   = IDX_W + 1;

  back_state_t state_r, state_nxt;

  logic [PIX_W-1:0]     pix_mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] above_r, pend_r, inc_r, inc_nxt;
  logic [IDX_W-1:0]     fidx_r;
  logic                 fup_r;

  logic                 b_valid_r;
  logic                 b_rim_r;
  logic                 b_last_r;
  logic [PIX_W-1:0]     rd_r;

  logic [OUT_CNT_W:0]   occ;
  logic                 space;
  logic                 run_go, flush_go, issue;

  logic [IDX_W-1:0]     j_idx;
  logic [MAX_WIDTH-1:0] j_mid;
  logic                 j_vert;
  logic [W_W-1:0]       idxp1;
  logic                 left_hit, right_hit, rim_sel, is_last;

  // Results in flight plus those queued must leave room for one more.
  assign occ   = {1'b0, out_cnt} + {{OUT_CNT_W{1'b0}}, b_valid_r};
  assign space = (occ < (OUT_CNT_W + 1)'(OUT_DEPTH));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (run_go && cmd_flags.frame_end) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (flush_go && is_last) begin
          state_nxt = BK_RUN;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    flush_go  = 1'b0;
    case (state_r)
      BK_RUN:   cmd_ready = cmd_valid && (space || !cmd_flags.emit);
      BK_FLUSH: flush_go  = space;
      default: begin
        cmd_ready = 1'b0;
        flush_go  = 1'b0;
      end
    endcase
  end

  assign run_go = cmd_ready;
  assign issue  = (run_go && cmd_flags.emit) || flush_go;

  // While running, a pixel of the awaiting row is judged against the row above
  // and the new pixel below it. While flushing, the last row is judged against its own pixels and the row above.
  always_comb begin
    if (state_r == BK_FLUSH) begin
      j_idx  = fidx_r;
      j_mid  = inc_r;
      j_vert = fup_r && pend_r[fidx_r];
    end else begin
      j_idx  = cmd_col;
      j_mid  = pend_r;
      j_vert = (cmd_flags.up_ok && above_r[cmd_col]) || cmd_flags.solid;
    end
  end

  assign idxp1     = {1'b0, j_idx} + W_W'(1);
  assign left_hit  = (j_idx != '0) ? j_mid[j_idx - IDX_W'(1)] : 1'b0;
  assign right_hit = (idxp1 < eff_w) ? j_mid[idxp1[IDX_W-1:0]] : 1'b0;
  assign rim_sel   = !j_mid[j_idx] && (j_vert || left_hit || right_hit);
  assign is_last   = (idxp1 == eff_w);

  always_comb begin
    inc_nxt = inc_r;
    if (run_go) begin
      inc_nxt[cmd_col] = cmd_flags.solid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_RUN;
      above_r   <= '0;
      pend_r    <= '0;
      inc_r     <= '0;
      fidx_r    <= '0;
      fup_r     <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      inc_r     <= inc_nxt;
      b_valid_r <= issue;
      if (run_go && cmd_flags.frame_end) begin
        fidx_r <= '0;
        fup_r  <= cmd_flags.emit;
      end else if (run_go && cmd_flags.row_end) begin
        above_r <= pend_r;
        pend_r  <= inc_nxt;
      end else if (flush_go) begin
        fidx_r <= idxp1[IDX_W-1:0];
      end
    end
  end

  // The read returns the colour stored before this cycle's write.
  always_ff @(posedge clk) begin
    if (run_go) begin
      pix_mem[cmd_col] <= cmd_pix;
    end
    if (issue) begin
      rd_r <= pix_mem[j_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_rim_r  <= rim_sel;
      b_last_r <= flush_go && is_last;
    end
  end

  assign res_valid = b_valid_r;
  assign res_pix   = b_rim_r ? rim : rd_r;
  assign res_last  = b_last_r;

endmodule

`default_nettype wire

>>> rtl/core/sor_checker.sv
`default_nettype none

`include "sprite_outline_rim_core_defines.svh"

module sor_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [7:0]                     in_red,
  input wire logic [7:0]                     in_green,
  input wire logic [7:0]                     in_blue,
  input wire logic [7:0]                     in_alpha,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [7:0]                     out_red,
  input wire logic [7:0]                     out_green,
  input wire logic [7:0]                     out_blue,
  input wire logic [7:0]                     out_alpha,
  input wire logic                           out_frame_end,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [sor_pkg::CFG_ADDR_W-1:0] paddr,
  input wire logic [31:0]                    pwdata,
  input wire logic [31:0]                    prdata,
  input wire logic                           pready
);

  import sor_pkg::*;

  // A request that is waiting must not change under the core.
  `SOR_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(in_red) && $stable(in_green) && $stable(in_blue)
      && $stable(in_alpha),
    "request changed while stalled")

  // A result that is waiting must not change under the consumer.
  `SOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(out_alpha) && $stable(out_frame_end),
    "result changed while stalled")

  // Leaving reset, both queues are empty.
  `SOR_ASSERT_SAME(a_reset_empty, $past(!rst_n), in_ready && !out_valid, "queues not empty after reset")

  // A width written over the bus reads back on the next cycle.
  `SOR_ASSERT_NEXT(a_width_rdback,
    psel && penable && pwrite && pready && (paddr[CFG_ADDR_W-1:2] == REG_WIDTH),
    (paddr != $past(paddr)) || (prdata[WREG_W-1:0] == $past(pwdata[WREG_W-1:0])),
    "width register readback mismatch")

endmodule

bind sprite_outline_rim_core sor_checker u_sor_checker (.*);

`default_nettype wire

>>> bench/sprite_outline_rim_core_tb.sv
`timescale 1ns / 100ps

module sprite_outline_rim_core_tb;

  localparam int AW          = sor_pkg::CFG_ADDR_W;
  localparam int SLOTS       = 32;
  localparam int DRAIN_WAIT  = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIXEL_GOAL  = 240;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } rim_pixel_t;

  // Tracks the outline that the core should draw and checks its output stream.
  class outline_scoreboard;
    logic [sor_pkg::WREG_W-1:0] width_reg;
    logic [sor_pkg::HREG_W-1:0] height_reg;
    logic [31:0]                rim;
    logic [31:0]                row_px [SLOTS];
    logic [SLOTS-1:0]           solid_above;
    logic [SLOTS-1:0]           solid_pending;
    logic [SLOTS-1:0]           solid_incoming;
    logic [SLOTS-1:0]           written;
    int                         col_cnt;
    int                         row_cnt;
    bit                         frame_done;
    int                         errors;
    rim_pixel_t                 expected [$];

    function new();
      width_reg      = sor_pkg::WIDTH_RST;
      height_reg     = sor_pkg::HEIGHT_RST;
      rim            = sor_pkg::RIM_RST;
      foreach (row_px[i]) row_px[i] = '0;
      solid_above    = '0;
      solid_pending  = '0;
      solid_incoming = '0;
      written        = '0;
      col_cnt        = 0;
      row_cnt        = 0;
      frame_done     = 1'b0;
      errors         = 0;
    endfunction

    function int clamp_width(int v);
      if (v == 0) return 1;
      if (v > SLOTS) return SLOTS;
      return v;
    endfunction

    function int clamp_height();
      if (height_reg == 0) return 1;
      if (height_reg > sor_pkg::MAX_HEIGHT) return int'(sor_pkg::MAX_HEIGHT);
      return int'(height_reg);
    endfunction

    // True when every pixel slot a frame of this width reads has been filled.
    function bit fits(int v);
      int w;
      w = clamp_width(v);
      for (int i = 0; i < w; i++) begin
        if (!written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void write_reg(sor_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        sor_pkg::REG_WIDTH:  width_reg = value[sor_pkg::WREG_W-1:0];
        sor_pkg::REG_HEIGHT: height_reg = value[sor_pkg::HREG_W-1:0];
        sor_pkg::REG_RIM:    rim = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(sor_pkg::reg_idx_t idx);
      case (idx)
        sor_pkg::REG_WIDTH:  return 32'(width_reg);
        sor_pkg::REG_HEIGHT: return 32'(height_reg);
        default:             return rim;
      endcase
    endfunction

    function logic [31:0] outline_colour(int x, int w, logic [31:0] colour,
                                         logic [SLOTS-1:0] mid, bit vert_hit);
      bit hit;
      if (mid[x]) return colour;
      hit = vert_hit;
      if (x > 0 && mid[x-1]) hit = 1'b1;
      if (x + 1 < w && mid[x+1]) hit = 1'b1;
      return hit ? rim : colour;
    endfunction

    function void queue_pixel(logic [31:0] colour, bit last);
      rim_pixel_t p;
      p.red       = colour[7:0];
      p.green     = colour[15:8];
      p.blue      = colour[23:16];
      p.alpha     = colour[31:24];
      p.frame_end = last;
      expected = {expected, p};
    endfunction

    function void note_pixel(logic [31:0] px);
      int w;
      int h;
      int x;
      int y;
      bit solid;
      bit row_end;
      bit last;
      w = clamp_width(int'(width_reg));
      h = clamp_height();
      x = col_cnt;
      y = row_cnt;
      if (x >= w) x = w - 1;
      solid   = (px[31:24] != 8'd0) && (px != rim);
      row_end = (col_cnt + 1 >= w);
      last    = row_end && (row_cnt + 1 >= h);
      frame_done = last;
      // The pixel above this one can now be judged from both sides.
      if (y > 0) begin
        queue_pixel(outline_colour(x, w, row_px[x], solid_pending,
                                   ((y > 1) && solid_above[x]) || solid), 1'b0);
      end
      row_px[x]         = px;
      solid_incoming[x] = solid;
      written[x]        = 1'b1;
      if (last) begin
        for (int i = 0; i < w; i++) begin
          queue_pixel(outline_colour(i, w, row_px[i], solid_incoming,
                                     (y > 0) && solid_pending[i]), i + 1 == w);
        end
        col_cnt = 0;
        row_cnt = 0;
      end else if (row_end) begin
        solid_above   = solid_pending;
        solid_pending = solid_incoming;
        col_cnt = 0;
        row_cnt = (row_cnt + 1) & 12'hFFF;
      end else begin
        col_cnt = (col_cnt + 1) & 5'h1F;
      end
    endfunction

    function void check_pixel(rim_pixel_t got);
      rim_pixel_t want;
      if (expected.size() == 0) begin
        $error("unexpected output pixel %h", got);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.red !== want.red) begin
        $error("out_red: expected %0h, got %0h", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green: expected %0h, got %0h", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue: expected %0h, got %0h", want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("out_alpha: expected %0h, got %0h", want.alpha, got.alpha);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("out_frame_end: expected %0h, got %0h", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [7:0]    in_red;
  logic [7:0]    in_green;
  logic [7:0]    in_blue;
  logic [7:0]    in_alpha;
  logic          out_valid;
  logic          out_ready;
  logic [7:0]    out_red;
  logic [7:0]    out_green;
  logic [7:0]    out_blue;
  logic [7:0]    out_alpha;
  logic          out_frame_end;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  outline_scoreboard board = new();
  int                pixels_sent = 0;
  int                cycles = 0;
  bit                src_calm = 1'b0;
  bit                sink_calm = 1'b0;

  sprite_outline_rim_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Writes one register, then reads it back.
  task automatic program_reg(input sor_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.write_reg(idx, value);
    want = board.reg_value(idx);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("prdata of %s: expected %0h, got %0h", idx.name(), want, prdata);
      board.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every outstanding pixel is out and the core has gone quiet.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [31:0] px);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_red   <= px[7:0];
    in_green <= px[15:8];
    in_blue  <= px[23:16];
    in_alpha <= px[31:24];
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_pixel(px);
    pixels_sent++;
  endtask

  function automatic logic [31:0] draw_pixel(logic [31:0] rim);
    case ($urandom_range(0, 9))
      0, 1, 2: return {8'h00, 24'($urandom)};
      3:       return rim;
      4:       return $urandom;
      default: return {8'($urandom_range(1, 255)), 24'($urandom)};
    endcase
  endfunction

  // A width the core can switch to now without reading a never-filled slot.
  function automatic logic [31:0] fitting_width();
    int v;
    v = $urandom_range(0, 63);
    if (!board.fits(v)) v = $urandom_range(1, board.col_cnt + 1);
    return 32'(v);
  endfunction

  task automatic run_frame();
    int  w;
    int  h;
    bit  tall;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = 32;
      2:       w = $urandom_range(33, 63);
      default: w = $urandom_range(1, 8);
    endcase
    tall = ($urandom_range(0, 7) == 0);
    if (tall) begin
      w = $urandom_range(1, 6);
      case ($urandom_range(0, 2))
        0:       h = 4096;
        1:       h = 8191;
        default: h = $urandom_range(4097, 8190);
      endcase
    end else if ($urandom_range(0, 7) == 0) begin
      h = 0;
    end else begin
      h = (w == 0 || w < 9) ? $urandom_range(1, 4) : $urandom_range(1, 2);
    end
    src_calm = ($urandom_range(0, 3) == 0);
    settle();
    program_reg(sor_pkg::REG_WIDTH, 32'(w));
    program_reg(sor_pkg::REG_HEIGHT, 32'(h));
    case ($urandom_range(0, 5))
      0:       program_reg(sor_pkg::REG_RIM, 32'h0000_0000);
      1:       program_reg(sor_pkg::REG_RIM, 32'hFFFF_FFFF);
      2:       program_reg(sor_pkg::REG_RIM, sor_pkg::RIM_RST);
      default: program_reg(sor_pkg::REG_RIM, $urandom);
    endcase
    do begin
      if (board.col_cnt == 0 && board.row_cnt > 0 &&
          (tall ? board.row_cnt >= 2 : $urandom_range(0, 15) == 0)) begin
        // Resize at a row boundary; a tall frame is cut short here.
        settle();
        if (tall) begin
          program_reg(sor_pkg::REG_HEIGHT, $urandom_range(0, board.row_cnt + 2));
          tall = 1'b0;
        end else begin
          case ($urandom_range(0, 2))
            0:       program_reg(sor_pkg::REG_HEIGHT, $urandom_range(0, board.row_cnt + 3));
            1:       program_reg(sor_pkg::REG_WIDTH, fitting_width());
            default: program_reg(sor_pkg::REG_RIM, $urandom);
          endcase
        end
      end else if (board.col_cnt > 0 && $urandom_range(0, 63) == 0) begin
        // Width changed in the middle of a row.
        settle();
        program_reg(sor_pkg::REG_WIDTH, fitting_width());
      end
      send_pixel(draw_pixel(board.rim));
    end while (!board.frame_done);
  endtask

  initial begin : result_sink
    int         stall;
    rim_pixel_t got;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {out_red, out_green, out_blue, out_alpha, out_frame_end};
      board.check_pixel(got);
    end
  end

  initial begin : stimulus
    logic [31:0] batch [$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    in_alpha = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Single-row frame: transparent, rim-coloured, white and faint pixels.
    settle();
    program_reg(sor_pkg::REG_WIDTH, 32'd4);
    program_reg(sor_pkg::REG_HEIGHT, 32'd1);
    batch = '{32'h0000_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 32'h01AB_CDEF};
    foreach (batch[i]) send_pixel(batch[i]);

    // A 3x3 shape with a custom rim, two pixels equal to it and a clear colour.
    settle();
    program_reg(sor_pkg::REG_WIDTH, 32'd3);
    program_reg(sor_pkg::REG_HEIGHT, 32'd3);
    program_reg(sor_pkg::REG_RIM, 32'h1234_5678);
    batch = '{32'h00FF_FFFF, 32'h0000_0000, 32'h8011_2233,
              32'h1234_5678, 32'hFF44_5566, 32'h1234_5678,
              32'hFFFF_FFFF, 32'h7F00_0000, 32'h0000_0000};
    foreach (batch[i]) send_pixel(batch[i]);

    // Zero sizes count as one pixel, then a one-pixel-wide column.
    settle();
    program_reg(sor_pkg::REG_WIDTH, 32'd0);
    program_reg(sor_pkg::REG_HEIGHT, 32'd0);
    send_pixel(32'hFF80_4020);
    settle();
    program_reg(sor_pkg::REG_WIDTH, 32'd1);
    program_reg(sor_pkg::REG_HEIGHT, 32'd3);
    batch = '{32'h0000_0000, 32'hC0C0_C0C0, 32'h1234_5678};
    foreach (batch[i]) send_pixel(batch[i]);

    while (pixels_sent < PIXEL_GOAL) run_frame();

    @(negedge clk) in_valid <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
